// ----- src/plaw_pkg.sv -----
// Package for the PID loop block: widths, register indexes, constants,
// multiplier select codes and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package plaw_pkg;

    // Field and register widths
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 24;
    localparam int LIM_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Internal widths
    localparam int ERR_W   = DATA_W + 1;          // raw error and error delta
    localparam int MUL_W   = DATA_W + 1;          // shared multiplier operands
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 56;                  // holds 250*(P+I+D) plus feedforward
    localparam int NUM_W   = 57;                  // dividend of the divide-by-ten unit
    localparam int DIVM_W  = NUM_W - 1;           // magnitude width inside the divider
    localparam int DIV_STEPS = DIVM_W / 8;        // one byte per cycle
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int INT_W   = 40;                  // integral plus increment before clamp
    localparam int Q_FRAC  = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_EN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_EN     = 3'd5;

    // Register reset values
    localparam logic [GAIN_W-1:0] RST_GAIN_P    = 24'd196608;
    localparam logic [GAIN_W-1:0] RST_GAIN_I    = 24'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_D    = 24'd131072;
    localparam logic [LIM_W-1:0]  RST_INT_LIMIT = 31'd2147483647;
    localparam logic              RST_WRAP_EN   = 1'b1;
    localparam logic              RST_FF_EN     = 1'b0;

    // Q16.16 constants
    localparam logic signed [ERR_W-1:0] PI_Q16     = 33'sd205887;
    localparam logic signed [ERR_W-1:0] NEG_PI_Q16 = -33'sd205887;
    localparam logic signed [ERR_W-1:0] TWO_PI_Q16 = 33'sd411775;
    localparam logic signed [DATA_W-1:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] INT32_MIN = 32'sh8000_0000;

    // Shared multiplier operand select
    localparam logic [1:0] MUL_SEL_P  = 2'd0;
    localparam logic [1:0] MUL_SEL_I  = 2'd1;
    localparam logic [1:0] MUL_SEL_D  = 2'd2;
    localparam logic [1:0] MUL_SEL_SQ = 2'd3;

    typedef struct packed {
        logic       load_in;
        logic       sub;
        logic       wrap_hi;
        logic       wrap_lo;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       diff;
        logic       acc_p;
        logic       div_start;
        logic       div_sel_ff;
        logic       int_upd;
        logic       acc_i;
        logic       prod_x10;
        logic       acc_d;
        logic       scale;
        logic       ff_b;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic ff_en;
    } t_sts;

endpackage

`default_nettype wire

// ----- src/plaw_in_if.sv -----
// Request channel: target and measured value with valid/ready.
// Depends on plaw_pkg.
`default_nettype none

interface plaw_in_if import plaw_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;

    modport source (output valid, output target, output measured, input ready);
    modport sink   (input valid, input target, input measured, output ready);
endinterface

`default_nettype wire

// ----- src/plaw_out_if.sv -----
// Result channel: saturated drive and clip flag with valid/ready.
// Depends on plaw_pkg.
`default_nettype none

interface plaw_out_if import plaw_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;
    logic                     saturated;

    modport source (output valid, output drive, output saturated, input ready);
    modport sink   (input valid, input drive, input saturated, output ready);
endinterface

`default_nettype wire

// ----- src/plaw_div10.sv -----
// Signed floor division by ten, one byte of the dividend per cycle.
// Depends on plaw_pkg.
`default_nettype none

module plaw_div10 import plaw_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    output logic                         o_done,
    output logic signed [NUM_W-1:0]      o_quot
);

    // x/10 == (x*6554)>>16 exactly for x < 2560
    localparam logic [12:0] RECIP10 = 13'd6554;
    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [3:0]           r_rem;
    logic [DIVM_W-1:0]    r_work;

    logic [11:0] v12;
    logic [24:0] qprod;
    logic [7:0]  qd;
    logic [11:0] qd_x10;
    logic [3:0]  rem_next;

    always_comb begin
        v12      = {r_rem, r_work[DIVM_W-1 -: 8]};
        qprod    = 25'(v12) * 25'(RECIP10);
        qd       = qprod[23:16];
        qd_x10   = 12'(qd) * 12'd10;
        rem_next = 4'(v12 - qd_x10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // negative dividend: floor(v/10) == ~(~v / 10)
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_num[NUM_W-1];
            r_rem  <= '0;
            r_work <= i_num[NUM_W-1] ? ~i_num[DIVM_W-1:0] : i_num[DIVM_W-1:0];
        end else if (r_busy) begin
            r_rem  <= rem_next;
            r_work <= {r_work[DIVM_W-9:0], qd};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? ~{1'b0, r_work} : {1'b0, r_work};

endmodule

`default_nettype wire

// ----- src/plaw_ctrl.sv -----
// Sequencer for one PID update: steps the datapath through error, gain
// products, integral, derivative, optional feedforward and output. Depends on plaw_pkg.
`default_nettype none

module plaw_ctrl import plaw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SUB     = 4'd1;
    localparam logic [3:0] S_WRAP_HI = 4'd2;
    localparam logic [3:0] S_WRAP_LO = 4'd3;
    localparam logic [3:0] S_MUL_P   = 4'd4;
    localparam logic [3:0] S_ACC_P   = 4'd5;
    localparam logic [3:0] S_DIV_I   = 4'd6;
    localparam logic [3:0] S_WAIT_I  = 4'd7;
    localparam logic [3:0] S_INTEG   = 4'd8;
    localparam logic [3:0] S_ACC_I   = 4'd9;
    localparam logic [3:0] S_ACC_D   = 4'd10;
    localparam logic [3:0] S_SCALE   = 4'd11;
    localparam logic [3:0] S_FF_B    = 4'd12;
    localparam logic [3:0] S_DIV_F   = 4'd13;
    localparam logic [3:0] S_WAIT_F  = 4'd14;
    localparam logic [3:0] S_FIN     = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_state = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_WRAP_HI;
            end
            S_WRAP_HI: begin
                o_cmd.wrap_hi = 1'b1;
                n_state       = S_WRAP_LO;
            end
            S_WRAP_LO: begin
                o_cmd.wrap_lo = 1'b1;
                n_state       = S_MUL_P;
            end
            S_MUL_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SEL_P;
                o_cmd.diff    = 1'b1;
                n_state       = S_ACC_P;
            end
            S_ACC_P: begin
                o_cmd.acc_p   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SEL_I;
                n_state       = S_DIV_I;
            end
            S_DIV_I: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT_I;
            end
            S_WAIT_I: begin
                if (i_sts.div_done) n_state = S_INTEG;
            end
            S_INTEG: begin
                o_cmd.int_upd = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SEL_D;
                n_state       = S_ACC_I;
            end
            S_ACC_I: begin
                o_cmd.acc_i    = 1'b1;
                o_cmd.prod_x10 = 1'b1;
                n_state        = S_ACC_D;
            end
            S_ACC_D: begin
                o_cmd.acc_d   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SEL_SQ;
                n_state       = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = i_sts.ff_en ? S_FF_B : S_FIN;
            end
            S_FF_B: begin
                o_cmd.ff_b = 1'b1;
                n_state    = S_DIV_F;
            end
            S_DIV_F: begin
                o_cmd.div_start  = 1'b1;
                o_cmd.div_sel_ff = 1'b1;
                n_state          = S_WAIT_F;
            end
            S_WAIT_F: begin
                if (i_sts.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- src/plaw_dp.sv -----
// Datapath: configuration registers, loop state, shared 33x33 multiplier,
// accumulator and output register. Depends on plaw_pkg and plaw_div10.
`default_nettype none

module plaw_dp import plaw_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  wire t_cmd                         i_cmd,
    output t_sts                              o_sts,
    input  wire logic signed [DATA_W-1:0]     i_target,
    input  wire logic signed [DATA_W-1:0]     i_measured,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic signed [DATA_W-1:0]          o_drive,
    output logic                              o_saturated
);

    // configuration
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;
    logic [LIM_W-1:0]  r_lim;
    logic              r_wrap_en;
    logic              r_ff_en;

    // loop state
    logic signed [DATA_W-1:0] r_int;
    logic signed [DATA_W-1:0] r_last;

    // working registers
    logic signed [DATA_W-1:0] r_t;
    logic signed [DATA_W-1:0] r_m;
    logic signed [ERR_W-1:0]  r_e;
    logic signed [DATA_W-1:0] r_err;
    logic signed [ERR_W-1:0]  r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [NUM_W-1:0]  r_num;

    // output register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_drive;
    logic                     r_sat;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ERR_W-1:0]  t_abs;
    logic signed [ERR_W-1:0]  e_lo;
    logic signed [DATA_W-1:0] err_sat;
    logic signed [INT_W-1:0]  int_sum;
    logic signed [INT_W-1:0]  lim_s;
    logic signed [DATA_W-1:0] int_next;
    logic signed [NUM_W-1:0]  sq;
    logic signed [NUM_W-1:0]  t_ext;
    logic signed [NUM_W-1:0]  div_num;
    logic signed [NUM_W-1:0]  div_q;
    logic                     div_done;
    logic signed [ACC_W-1:0]  ff;
    logic signed [ACC_W-1:0]  total;
    logic                     total_ovf;

    plaw_div10 u_div10 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // shared multiplier
    always_comb begin
        t_abs = r_t[DATA_W-1] ? -ERR_W'(r_t) : ERR_W'(r_t);
        case (i_cmd.mul_sel)
            MUL_SEL_P: begin
                mul_a = signed'(MUL_W'(r_gain_p));
                mul_b = MUL_W'(r_err);
            end
            MUL_SEL_I: begin
                mul_a = signed'(MUL_W'(r_gain_i));
                mul_b = MUL_W'(r_err);
            end
            MUL_SEL_D: begin
                mul_a = signed'(MUL_W'(r_gain_d));
                mul_b = r_diff;
            end
            default: begin
                mul_a = t_abs;
                mul_b = MUL_W'(r_t);
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb begin
        // second half of the angle wrap, then clip to 32 bits
        e_lo = (r_wrap_en && (r_e < NEG_PI_Q16)) ? r_e + TWO_PI_Q16 : r_e;
        if (e_lo[ERR_W-1] != e_lo[ERR_W-2]) begin
            err_sat = e_lo[ERR_W-1] ? INT32_MIN : INT32_MAX;
        end else begin
            err_sat = e_lo[DATA_W-1:0];
        end

        int_sum = INT_W'(r_int) + INT_W'(div_q);
        lim_s   = signed'(INT_W'(r_lim));
        if (int_sum > lim_s) begin
            int_next = DATA_W'(lim_s);
        end else if (int_sum < -lim_s) begin
            int_next = DATA_W'(-lim_s);
        end else begin
            int_next = DATA_W'(int_sum);
        end

        sq      = NUM_W'(r_prod >>> Q_FRAC);
        t_ext   = NUM_W'(r_t);
        div_num = i_cmd.div_sel_ff ? r_num : NUM_W'(r_prod >>> Q_FRAC);

        ff        = r_ff_en ? ACC_W'(div_q) : '0;
        total     = r_acc + ff;
        total_ovf = !((&total[ACC_W-1:DATA_W-1]) || !(|total[ACC_W-1:DATA_W-1]));
    end

    // configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p  <= RST_GAIN_P;
            r_gain_i  <= RST_GAIN_I;
            r_gain_d  <= RST_GAIN_D;
            r_lim     <= RST_INT_LIMIT;
            r_wrap_en <= RST_WRAP_EN;
            r_ff_en   <= RST_FF_EN;
            r_int     <= '0;
            r_last    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAIN_P:    r_gain_p  <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:    r_gain_i  <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:    r_gain_d  <= i_cfg_data[GAIN_W-1:0];
                    CFG_INT_LIMIT: r_lim     <= i_cfg_data[LIM_W-1:0];
                    CFG_WRAP_EN:   r_wrap_en <= i_cfg_data[0];
                    CFG_FF_EN:     r_ff_en   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.int_upd) r_int  <= int_next;
            if (i_cmd.fin)     r_last <= r_err;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_t <= i_target;
            r_m <= i_measured;
        end
        if (i_cmd.sub) begin
            r_e <= ERR_W'(r_t) - ERR_W'(r_m);
        end else if (i_cmd.wrap_hi && r_wrap_en && (r_e > PI_Q16)) begin
            r_e <= r_e - TWO_PI_Q16;
        end
        if (i_cmd.wrap_lo) r_err  <= err_sat;
        if (i_cmd.diff)    r_diff <= ERR_W'(r_err) - ERR_W'(r_last);

        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end else if (i_cmd.prod_x10) begin
            r_prod <= (r_prod <<< 3) + (r_prod <<< 1);
        end

        if (i_cmd.acc_p) begin
            r_acc <= ACC_W'(r_prod >>> Q_FRAC);
        end else if (i_cmd.acc_i) begin
            r_acc <= r_acc + ACC_W'(r_int);
        end else if (i_cmd.acc_d) begin
            r_acc <= r_acc + ACC_W'(r_prod >>> Q_FRAC);
        end else if (i_cmd.scale) begin
            // x250 = x256 - x4 - x2
            r_acc <= (r_acc <<< 8) - (r_acc <<< 2) - (r_acc <<< 1);
        end

        if (i_cmd.scale) begin
            // x724 = x512 + x128 + x64 + x16 + x4
            r_num <= (sq <<< 9) + (sq <<< 7) + (sq <<< 6) + (sq <<< 4) + (sq <<< 2);
        end else if (i_cmd.ff_b) begin
            r_num <= r_num + (t_ext <<< 9) + t_ext;
        end

        if (i_cmd.fin) begin
            r_sat   <= total_ovf;
            r_drive <= total_ovf ? (total[ACC_W-1] ? INT32_MIN : INT32_MAX)
                                 : total[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.ff_en    = r_ff_en;

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_saturated = r_sat;

endmodule

`default_nettype wire

// ----- src/pid_loop_angle_wrap_feedforward_core.sv -----
// PID channel, Q16.16, with angle wrap, clamped integral and speed feedforward.
// One request is processed at a time: a new one is accepted only once the previous
// result has entered the output register. Work is paced by the byte-serial
// divide-by-ten unit and the single shared multiplier.
// Reset (synchronous, active low) restores register defaults and clears the integral
// and last error. Depends on plaw_pkg, plaw_in_if, plaw_out_if, plaw_ctrl, plaw_dp.
`default_nettype none

module pid_loop_angle_wrap_feedforward_core import plaw_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    plaw_in_if.sink                    i_req,
    plaw_out_if.source                 o_rsp
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    plaw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    plaw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_target    (i_req.target),
        .i_measured  (i_req.measured),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_drive     (o_rsp.drive),
        .o_saturated (o_rsp.saturated)
    );

    assign i_req.ready = in_ready;

endmodule

`default_nettype wire
